// File: rtl/core/imk_pkg.sv
`default_nettype none

package imk_pkg;

  localparam logic [63:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam logic [7:0]  KEY_TWEAK  = 8'hAA;

  // byte lane offsets of the second and third mask bytes (24 and 56 bits)
  localparam logic [2:0]  LANE_OFS_B = 3'd3;
  localparam logic [2:0]  LANE_OFS_C = 3'd7;

  // cycles from an accepted start to its done strobe
  localparam int unsigned PIPE_DEPTH = 10;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] lane;
  } side_t;

  function automatic logic [7:0] lane_byte(input logic [63:0] w, input logic [2:0] lane);
    logic [7:0] b;
    b = w[{lane, 3'b000} +: 8];
    return b;
  endfunction

  function automatic logic [7:0] mask_byte(input logic [63:0] w, input logic [2:0] lane);
    logic [2:0] lb;
    logic [2:0] lc;
    lb = lane + LANE_OFS_B;
    lc = lane + LANE_OFS_C;
    return lane_byte(w, lane) ^ lane_byte(w, lb) ^ lane_byte(w, lc);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/imk_mul64.sv
`default_nettype none

// low 64 bits of a 64x64 product over two stages of 32-bit partial products
module imk_mul64 (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire logic [63:0]     a,
  input  wire logic [63:0]     b,
  input  wire imk_pkg::side_t  in_side,
  output logic                 out_vld,
  output logic [63:0]          p,
  output imk_pkg::side_t       out_side
);

  logic                 vld1;
  logic [63:0]          ll;
  logic [31:0]          lh;
  logic [31:0]          hl;
  imk_pkg::side_t       side1;
  logic [31:0]          mid_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    ll       <= 64'(a[31:0]) * 64'(b[31:0]);
    lh       <= 32'(a[31:0] * b[63:32]);
    hl       <= 32'(a[63:32] * b[31:0]);
    side1    <= in_side;
    p        <= ll + {mid_sum, 32'b0};
    out_side <= side1;
  end

  assign mid_sum = lh + hl;

endmodule

`default_nettype wire

// File: rtl/core/indexed_mix_keystream_byte_cipher_core.sv
`default_nettype none

// Keyed byte transform with a position-indexed splitmix64 keystream. A byte is
// accepted on every cycle that start is high (busy is always low) and its
// result appears on data_out with a one-cycle done strobe, in order, after
// passing through the three 64-bit multiplies (position by the golden-ratio
// constant and the two finalizer multiplies), each split into two stages of
// 32-bit partial products, and the xor-shift, mask and output stages; the
// receiver cannot stall. The key is written through cfg_we/cfg_data and must
// only change while no byte is in flight.
module indexed_mix_keystream_byte_cipher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  data_in,
  input  wire logic [31:0] byte_index,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_data,
  output logic             done,
  output logic [7:0]       data_out
);

  logic [63:0]     cipher_key;

  logic            acc;
  imk_pkg::side_t  side0;

  logic            m0_vld;
  logic [63:0]     m0_p;
  imk_pkg::side_t  m0_side;

  logic            x_vld;
  logic [63:0]     x;
  imk_pkg::side_t  x_side;
  logic [63:0]     z;

  logic            m1_vld;
  logic [63:0]     m1_p;
  imk_pkg::side_t  m1_side;

  logic            u_vld;
  logic [63:0]     u;
  imk_pkg::side_t  u_side;

  logic            m2_vld;
  logic [63:0]     m2_p;
  imk_pkg::side_t  m2_side;

  logic            k_vld;
  logic [7:0]      mask;
  imk_pkg::side_t  k_side;
  logic [63:0]     w;

  logic [7:0]      kb0;
  logic [7:0]      kb1;
  logic [7:0]      sum;

  assign busy  = 1'b0;
  assign acc   = start && !busy;
  assign side0 = '{data: data_in, lane: byte_index[2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= 64'b0;
    end else if (cfg_we) begin
      cipher_key <= cfg_data;
    end
  end

  // position times golden-ratio constant
  imk_mul64 u_mul_pos (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (acc),
    .a        ({32'b0, byte_index}),
    .b        (imk_pkg::GOLDEN_MUL),
    .in_side  (side0),
    .out_vld  (m0_vld),
    .p        (m0_p),
    .out_side (m0_side)
  );

  assign z = cipher_key ^ m0_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else begin
      x_vld <= m0_vld;
    end
  end

  always_ff @(posedge clk) begin
    x      <= z ^ (z >> 30);
    x_side <= m0_side;
  end

  imk_mul64 u_mul_a (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (x_vld),
    .a        (x),
    .b        (imk_pkg::MIX_MUL_A),
    .in_side  (x_side),
    .out_vld  (m1_vld),
    .p        (m1_p),
    .out_side (m1_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      u_vld <= 1'b0;
    end else begin
      u_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    u      <= m1_p ^ (m1_p >> 27);
    u_side <= m1_side;
  end

  imk_mul64 u_mul_b (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (u_vld),
    .a        (u),
    .b        (imk_pkg::MIX_MUL_B),
    .in_side  (u_side),
    .out_vld  (m2_vld),
    .p        (m2_p),
    .out_side (m2_side)
  );

  assign w = m2_p ^ (m2_p >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else begin
      k_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    mask   <= imk_pkg::mask_byte(w, m2_side.lane);
    k_side <= m2_side;
  end

  // key-derived additive offsets
  assign kb0 = cipher_key[7:0] ^ imk_pkg::KEY_TWEAK;
  assign kb1 = cipher_key[15:8];
  assign sum = k_side.data + kb1 - kb0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= sum ^ mask;
  end

  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, imk_pkg::PIPE_DEPTH))
    else $error("done without a start transfer one pipeline depth earlier");

  a_reset_flushes: assert property (@(posedge clk)
    rst |=> !done && !k_vld && !u_vld && !x_vld)
    else $error("pipeline valid survived reset");

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    k_vld |-> $past(u_vld, 3) && $past(x_vld, 6))
    else $error("stage valid out of step with earlier stages");

endmodule

`default_nettype wire
